[rtl/core/assert_macros.svh]
// Assertion helper macros, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[rtl/core/nngc_pkg.sv]
// ----------------------------------------------------------------------------
// nngc_pkg
// Constants, types and tables of the nearest node search.
// ----------------------------------------------------------------------------
package nngc_pkg;
  localparam int NodeDepthDef = 1024;
  localparam int CoordBitsDef = 16;
  localparam int CountW       = 11;
  localparam int SlotW        = 10;
  localparam int IdW          = 32;
  localparam int DistW        = 16;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 32;
  localparam int CordicSteps  = 17;
  localparam int PiQ13        = 25736;
  localparam int HalfPiQ16    = 102944;
  localparam logic [CfgIdxW-1:0] RegNodeCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRadius    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxDist   = 2'd2;

  // datapath commands and status
  typedef struct packed {
    logic start;   // latch query, clear best
    logic issue;   // launch one slot into the pipe
    logic deliver; // hand the result to the output register
  } cmd_t;

  typedef struct packed {
    logic busy;    // slots still in flight
  } stat_t;

  function automatic logic [17:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 18'd51472;  5'd1: atan_q16 = 18'd30386;
      5'd2: atan_q16 = 18'd16055;  5'd3: atan_q16 = 18'd8150;
      5'd4: atan_q16 = 18'd4091;   5'd5: atan_q16 = 18'd2047;
      5'd6: atan_q16 = 18'd1024;   5'd7: atan_q16 = 18'd512;
      5'd8: atan_q16 = 18'd256;    5'd9: atan_q16 = 18'd128;
      5'd10: atan_q16 = 18'd64;    5'd11: atan_q16 = 18'd32;
      5'd12: atan_q16 = 18'd16;    5'd13: atan_q16 = 18'd8;
      5'd14: atan_q16 = 18'd4;     5'd15: atan_q16 = 18'd2;
      5'd16: atan_q16 = 18'd1;
      default: atan_q16 = 18'd0;
    endcase
  endfunction
endpackage

[rtl/core/nngc_if.sv]
// ----------------------------------------------------------------------------
// nngc_in_if / nngc_out_if / nngc_cfg_if
// Valid/ready channels of the nearest node search.
// ----------------------------------------------------------------------------
interface nngc_in_if #(parameter int CoordW = 16);
  logic              valid;
  logic              ready;
  logic              func;
  logic [9:0]        slot;
  logic [CoordW-1:0] coord_x;
  logic [CoordW-1:0] coord_y;
  logic [CoordW-1:0] coord_z;
  logic [31:0]       ident;
  modport source (output valid, func, slot, coord_x, coord_y, coord_z, ident, input ready);
  modport sink (input valid, func, slot, coord_x, coord_y, coord_z, ident, output ready);
endinterface

interface nngc_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [9:0]  nearest_slot;
  logic [31:0] nearest_id;
  logic [31:0] resource_id;
  logic [15:0] distance;
  modport source (output valid, found, nearest_slot, nearest_id, resource_id, distance,
                  input ready);
  modport sink (input valid, found, nearest_slot, nearest_id, resource_id, distance,
                output ready);
endinterface

interface nngc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/nngc_isqrt.sv]
// ----------------------------------------------------------------------------
// nngc_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module nngc_isqrt #(
  parameter int InW = 61,
  parameter int TagW = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [InW-1:0]          in_val,
  input  logic [TagW-1:0]         in_tag,
  output logic                    out_valid,
  output logic [(InW+1)/2-1:0]    out_root,
  output logic [TagW-1:0]         out_tag
);
  localparam int RootW = (InW + 1) / 2;
  localparam int RemW  = RootW + 2;
  localparam int PadW  = 2 * RootW;

  logic [PadW-1:0]  rad   [RootW+1];
  logic [RemW-1:0]  rem   [RootW+1];
  logic [RootW-1:0] root  [RootW+1];
  logic [TagW-1:0]  tag   [RootW+1];
  logic             vld   [RootW+1];

  always_comb begin
    rad[0]  = PadW'(in_val);
    rem[0]  = '0;
    root[0] = '0;
    tag[0]  = in_tag;
    vld[0]  = in_valid;
  end

  for (genvar g = 0; g < RootW; g++) begin : g_stage
    logic [RemW-1:0] trial;
    logic [RemW-1:0] shifted;
    always_comb begin
      shifted = {rem[g][RemW-3:0], rad[g][PadW-1 -: 2]};
      trial   = {root[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      rad[g+1] <= {rad[g][PadW-3:0], 2'b00};
      tag[g+1] <= tag[g];
      if (shifted >= trial) begin
        rem[g+1]  <= shifted - trial;
        root[g+1] <= {root[g][RootW-2:0], 1'b1};
      end else begin
        rem[g+1]  <= shifted;
        root[g+1] <= {root[g][RootW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[RootW];
  assign out_root  = root[RootW];
  assign out_tag   = tag[RootW];
endmodule

[rtl/core/nngc_datapath.sv]
// ----------------------------------------------------------------------------
// nngc_datapath
// Node memory, dot product, square root, CORDIC angle, scaling, best search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module nngc_datapath #(
  parameter int NodeDepth = nngc_pkg::NodeDepthDef,
  parameter int CoordBits = nngc_pkg::CoordBitsDef
) (
  input  logic                            clk,
  input  logic                            rst,
  input  nngc_pkg::cmd_t                  cmd,
  output nngc_pkg::stat_t                 stat,
  input  logic                            load_en,
  input  logic [nngc_pkg::SlotW-1:0]      load_slot,
  input  logic [CoordBits-1:0]            in_x,
  input  logic [CoordBits-1:0]            in_y,
  input  logic [CoordBits-1:0]            in_z,
  input  logic [nngc_pkg::IdW-1:0]        in_ident,
  input  logic [$clog2(NodeDepth)-1:0]    issue_slot,
  input  logic [nngc_pkg::DistW-1:0]      sphere_radius,
  input  logic [nngc_pkg::DistW-1:0]      max_distance,
  output logic                            res_found,
  output logic [nngc_pkg::SlotW-1:0]      res_slot,
  output logic [nngc_pkg::IdW-1:0]        res_id,
  output logic [nngc_pkg::IdW-1:0]        res_rid,
  output logic [nngc_pkg::DistW-1:0]      res_dist
);
  import nngc_pkg::*;

  localparam int AW    = $clog2(NodeDepth);
  localparam int CW    = CoordBits;
  localparam int PW    = 2 * CW;
  localparam int SW    = PW + 2;
  localparam int Frac  = 2 * (CW - 1);
  localparam int DW    = 32;          // Q2.30 clamped dot
  localparam int SqW   = 61;
  localparam int RootW = (SqW + 1) / 2;
  localparam int XW    = 36;          // CORDIC x/y width
  localparam int ZW    = 20;
  localparam int TagW  = AW + DW;
  localparam int InFl  = 8;           // pipeline depth counter width

  logic [3*CW-1:0] pos_mem [NodeDepth];
  logic [IdW-1:0]  id_mem  [NodeDepth];
  logic [3*CW-1:0] pos_rd;
  logic [IdW-1:0]  id_rd;
  logic [AW-1:0]   rd_slot, win_slot_q;
  logic            rd_vld;

  logic signed [CW-1:0] qx, qy, qz;
  logic [IdW-1:0]       qid;

  // node memory
  always_ff @(posedge clk) begin
    if (load_en && (32'(load_slot) < NodeDepth)) begin
      pos_mem[AW'(load_slot)] <= {in_x, in_y, in_z};
      id_mem[AW'(load_slot)]  <= in_ident;
    end
    pos_rd  <= pos_mem[issue_slot];
    rd_slot <= issue_slot;
  end
  always_ff @(posedge clk) begin
    id_rd <= id_mem[win_slot_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx <= in_x; qy <= in_y; qz <= in_z; qid <= in_ident;
    end
  end

  // stage 1: products
  logic signed [PW-1:0] p0, p1, p2;
  logic [AW-1:0] s1_slot;
  logic s1_vld;
  always_ff @(posedge clk) begin
    p0 <= qx * $signed(pos_rd[3*CW-1 -: CW]);
    p1 <= qy * $signed(pos_rd[2*CW-1 -: CW]);
    p2 <= qz * $signed(pos_rd[CW-1:0]);
    s1_slot <= rd_slot;
  end

  // stage 2: sum, scale to Q2.30, clamp
  logic signed [SW-1:0] dsum;
  logic signed [SW+30:0] dscl;
  logic signed [DW-1:0] d2;
  logic [AW-1:0] s2_slot;
  logic s2_vld;
  always_comb begin
    dsum = SW'(p0) + SW'(p1) + SW'(p2);
    if (Frac >= 30) dscl = (SW+31)'(dsum >>> (Frac >= 30 ? Frac - 30 : 0));
    else            dscl = (SW+31)'(dsum) <<< (Frac < 30 ? 30 - Frac : 0);
  end
  always_ff @(posedge clk) begin
    if (dscl > (SW+31)'(64'sd1073741824))       d2 <= 32'sd1073741824;
    else if (dscl < -(SW+31)'(64'sd1073741824)) d2 <= -32'sd1073741824;
    else                                        d2 <= DW'(dscl);
    s2_slot <= s1_slot;
  end

  // stage 3: square
  logic [AW-1:0] dd_abs_w;
  logic [30:0]   dabs;
  logic [61:0]   dsq;
  logic [SqW-1:0] sq_in;
  logic [TagW-1:0] sq_tag;
  logic s3_vld;
  assign dabs = d2[31] ? 31'(-d2) : 31'(d2);
  assign dsq  = dabs * dabs;
  always_ff @(posedge clk) begin
    sq_in  <= SqW'(61'h1000000000000000) - SqW'(dsq);
    sq_tag <= {s2_slot, d2};
  end
  assign dd_abs_w = s2_slot;

  logic sq_vld;
  logic [RootW-1:0] sroot;
  logic [TagW-1:0] sr_tag;
  nngc_isqrt #(.InW(SqW), .TagW(TagW)) u_sqrt (
    .clk, .rst, .in_valid(s3_vld), .in_val(sq_in), .in_tag(sq_tag),
    .out_valid(sq_vld), .out_root(sroot), .out_tag(sr_tag)
  );

  // CORDIC stages
  logic signed [XW-1:0] cx [CordicSteps+1];
  logic signed [XW-1:0] cy [CordicSteps+1];
  logic signed [ZW-1:0] cz [CordicSteps+1];
  logic [AW-1:0]        cs [CordicSteps+1];
  logic                 cv [CordicSteps+1];
  logic signed [DW-1:0] dq;
  assign dq = sr_tag[DW-1:0];
  always_comb begin
    cs[0] = sr_tag[TagW-1 -: AW];
    cv[0] = sq_vld;
    if (dq[DW-1]) begin
      cx[0] = XW'($signed({1'b0, sroot}));
      cy[0] = -XW'(dq);
      cz[0] = ZW'(HalfPiQ16);
    end else begin
      cx[0] = XW'(dq);
      cy[0] = XW'($signed({1'b0, sroot}));
      cz[0] = '0;
    end
  end
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else     cv[i+1] <= cv[i];
      cs[i+1] <= cs[i];
      if (!cy[i][XW-1]) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ZW'(atan_q16(5'(i)));
      end else begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ZW'(atan_q16(5'(i)));
      end
    end
  end

  // angle rounding and scaling
  logic signed [ZW-1:0] zr;
  logic [14:0] ang;
  logic [AW-1:0] a_slot, m_slot;
  logic a_vld, m_vld;
  logic [31:0] prod;
  assign zr = (cz[CordicSteps] + $signed(ZW'(4))) >>> 3;
  always_ff @(posedge clk) begin
    if (zr < 0)                 ang <= '0;
    else if (zr > ZW'(PiQ13))   ang <= 15'(PiQ13);
    else                        ang <= 15'(zr);
    a_slot <= cs[CordicSteps];
    prod   <= 32'(sphere_radius) * 32'(ang);
    m_slot <= a_slot;
  end
  logic [18:0] dscale;
  logic [DistW-1:0] ndist;
  assign dscale = 19'((prod + 32'd4096) >> 13);
  assign ndist  = (dscale > 19'd65535) ? 16'hFFFF : DistW'(dscale);

  // best search
  logic [DistW-1:0] best;
  logic best_found;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best <= max_distance;
      best_found <= 1'b0;
      win_slot_q <= '0;
    end else if (m_vld && ndist < best) begin
      best <= ndist;
      best_found <= 1'b1;
      win_slot_q <= m_slot;
    end
  end

  // valid tracking down the fixed pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0; s1_vld <= 1'b0; s2_vld <= 1'b0; s3_vld <= 1'b0;
      a_vld <= 1'b0; m_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue; s1_vld <= rd_vld; s2_vld <= s1_vld; s3_vld <= s2_vld;
      a_vld <= cv[CordicSteps]; m_vld <= a_vld;
    end
  end

  // in-flight count
  logic [InFl-1:0] inflight;
  logic retire;
  assign retire = m_vld;
  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + InFl'(cmd.issue) - InFl'(retire);
  end
  // the id read is registered behind the last compare, so tail keeps busy up while it completes
  logic tail;
  always_ff @(posedge clk) begin
    if (rst) tail <= 1'b0;
    else tail <= retire;
  end
  assign stat.busy = (inflight != '0) || tail || retire;

  assign res_found = best_found;
  assign res_slot  = best_found ? SlotW'(win_slot_q) : '0;
  assign res_id    = best_found ? id_rd : '0;
  assign res_rid   = qid;
  assign res_dist  = best;

  logic unused_ok;
  assign unused_ok = cmd.deliver ^ (|dd_abs_w);

  `ASSERT_IMPL(a_no_issue_on_start, clk, rst, !(cmd.start && cmd.issue), "start with issue")
  `ASSERT_IMPL(a_retire_needs_flight, clk, rst, m_vld |-> (inflight != '0), "retire unmatched")
  `ASSERT_IMPL(a_better_sets_found, clk, rst, (m_vld && (ndist < best)) |=> best_found, "best lost")
endmodule

[rtl/core/nngc_ctrl.sv]
// ----------------------------------------------------------------------------
// nngc_ctrl
// Sequencer: takes items, issues slots, waits for the pipe, delivers result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module nngc_ctrl #(
  parameter int NodeDepth = nngc_pkg::NodeDepthDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_func,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic [nngc_pkg::CountW-1:0]    node_count,
  output nngc_pkg::cmd_t                 cmd,
  input  nngc_pkg::stat_t                stat,
  output logic                           load_en,
  output logic [$clog2(NodeDepth)-1:0]   issue_slot
);
  import nngc_pkg::*;
  localparam int AW = $clog2(NodeDepth);
  localparam int NW = AW + 1;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state, state_next;
  logic [NW-1:0] cnt, limit;
  logic [CountW:0] nc_sat;
  logic acc;
  logic out_valid_q_busy;

  assign nc_sat = (32'(node_count) > NodeDepth) ? (CountW+1)'(NodeDepth)
                                                : (CountW+1)'(node_count);
  assign out_valid_q_busy = out_valid && !out_ready;
  assign in_ready  = (state == StIdle) && !out_valid_q_busy;
  assign acc = in_valid && in_ready;
  assign load_en = acc && !in_func;
  assign issue_slot = AW'(cnt);

  always_comb begin
    state_next  = state;
    cmd.start   = 1'b0;
    cmd.issue   = 1'b0;
    cmd.deliver = 1'b0;
    case (state)
      StIdle: if (acc && in_func) begin
        cmd.start = 1'b1;
        state_next = StScan;
      end
      StScan: begin
        if (cnt == limit) state_next = StWait;
        else cmd.issue = 1'b1;
      end
      StWait: if (!stat.busy) state_next = StOut;
      StOut: begin
        cmd.deliver = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt <= '0;
      limit <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        cnt <= '0;
        limit <= NW'(nc_sat);
      end else if (cmd.issue) begin
        cnt <= cnt + NW'(1);
      end
      if (cmd.deliver) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPL(a_cnt_bound, clk, rst, cnt <= limit, "slot counter overran")
  `ASSERT_IMPL(a_issue_in_scan, clk, rst, cmd.issue |-> (state == StScan), "issue outside scan")
  `ASSERT_IMPL(a_deliver_free, clk, rst, cmd.deliver |-> !out_valid_q_busy, "output overwritten")
endmodule

[rtl/core/nearest_node_great_circle_top.sv]
// Loads are taken one per cycle while the sequencer is idle and the result is not stalled; a
// query with node_count N >= 1 gives its result after the slot scan issues its N slots, the
// distance pipe drains and the result is handed to the output register (empty scan for N = 0).
// No new load or query is taken until the previous query's result has been delivered.
// Reset (rst, synchronous, active high) clears control and the registers
// (node_count 0, sphere_radius 6371, max_distance 65535); node memory is kept.
// ----------------------------------------------------------------------------
// nearest_node_great_circle_top
// Nearest stored node to a query vector by great-circle distance.
// ----------------------------------------------------------------------------
module nearest_node_great_circle_top #(
  parameter int NODE_DEPTH = nngc_pkg::NodeDepthDef,
  parameter int COORD_BITS = nngc_pkg::CoordBitsDef
) (
  input logic       clk,
  input logic       rst,
  nngc_in_if.sink   in_ch,
  nngc_out_if.source out_ch,
  nngc_cfg_if.sink  cfg
);
  import nngc_pkg::*;
  localparam int AW = $clog2(NODE_DEPTH);

  logic [CountW-1:0] node_count;
  logic [DistW-1:0]  sphere_radius, max_distance;
  cmd_t  cmd;
  stat_t stat;
  logic  load_en, ovalid;
  logic [AW-1:0] issue_slot;
  logic r_found;
  logic [SlotW-1:0] r_slot;
  logic [IdW-1:0] r_id, r_rid;
  logic [DistW-1:0] r_dist;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      sphere_radius <= 16'd6371;
      max_distance <= 16'hFFFF;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegNodeCount: node_count <= CountW'(cfg.data);
        RegRadius:    sphere_radius <= DistW'(cfg.data);
        RegMaxDist:   max_distance <= DistW'(cfg.data);
        default: ;
      endcase
    end
  end

  nngc_ctrl #(.NodeDepth(NODE_DEPTH)) u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_func(in_ch.func), .in_ready(in_ch.ready),
    .out_valid(ovalid), .out_ready(out_ch.ready), .node_count, .cmd, .stat,
    .load_en, .issue_slot
  );

  nngc_datapath #(.NodeDepth(NODE_DEPTH), .CoordBits(COORD_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .load_en, .load_slot(in_ch.slot),
    .in_x(in_ch.coord_x), .in_y(in_ch.coord_y), .in_z(in_ch.coord_z),
    .in_ident(in_ch.ident), .issue_slot, .sphere_radius, .max_distance,
    .res_found(r_found), .res_slot(r_slot), .res_id(r_id), .res_rid(r_rid),
    .res_dist(r_dist)
  );

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_ch.found <= r_found;
      out_ch.nearest_slot <= r_slot;
      out_ch.nearest_id <= r_id;
      out_ch.resource_id <= r_rid;
      out_ch.distance <= r_dist;
    end
  end
  assign out_ch.valid = ovalid;
endmodule

[tb/sv/nngc_checker.sv]
// ----------------------------------------------------------------------------
// nngc_checker
// Watches the load/query, result and register channels, predicts every query
// result from its own copy of the node table and registers, and compares.
// ----------------------------------------------------------------------------
package nngc_tb_pkg;
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;
endpackage

module nngc_checker (
  input  logic clk,
  input  logic rst,
  nngc_in_if   in_ch,
  nngc_out_if  out_ch,
  nngc_cfg_if  cfg,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import nngc_pkg::*;
  import nngc_tb_pkg::*;

  typedef struct {
    logic        found;
    logic [9:0]  nearest_slot;
    logic [31:0] nearest_id;
    logic [31:0] resource_id;
    logic [15:0] distance;
  } answer_t;

  localparam longint ArcTab [CordicSteps] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1
  };

  logic [10:0]        count_q;
  logic [15:0]        radius_q;
  logic [15:0]        limit_q;
  logic signed [15:0] pos_x [NodeDepthDef];
  logic signed [15:0] pos_y [NodeDepthDef];
  logic signed [15:0] pos_z [NodeDepthDef];
  logic [31:0]        node_id [NodeDepthDef];
  answer_t            answers [$];

  assign pending = answers.size();

  initial begin
    fails = 0;
    for (int i = 0; i < NodeDepthDef; i++) begin
      pos_x[i] = '0; pos_y[i] = '0; pos_z[i] = '0; node_id[i] = '0;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // central angle in Q3.13 from a clamped Q2.30 cosine
  function automatic longint angle_q13(longint d);
    longint unsigned dd;
    longint x, y, z, xs, ys, a;
    dd = (d < 0) ? -d : d;
    y = longint'(int_sqrt((64'd1 << 60) - dd * dd));
    x = d;
    z = 0;
    if (x < 0) begin
      x = y;
      y = -d;
      z = HalfPiQ16;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ArcTab[i];
      end else begin
        x -= ys; y += xs; z -= ArcTab[i];
      end
    end
    a = (z + 4) >>> 3;
    if (a < 0) a = 0;
    if (a > PiQ13) a = PiQ13;
    return a;
  endfunction

  function automatic logic [15:0] arc_distance(logic signed [15:0] qx, qy, qz, int j);
    longint dot, lim;
    longint unsigned arc_len;
    lim = 64'sd1 <<< 30;
    dot = longint'(qx) * pos_x[j] + longint'(qy) * pos_y[j] + longint'(qz) * pos_z[j];
    if (dot > lim) dot = lim;
    if (dot < -lim) dot = -lim;
    arc_len = (longint'(radius_q) * angle_q13(dot) + 4096) >> 13;
    if (arc_len > 65535) arc_len = 65535;
    return arc_len[15:0];
  endfunction

  function automatic answer_t nearest_node(logic signed [15:0] qx, qy, qz, logic [31:0] rid);
    answer_t r;
    int n;
    logic [15:0] d;
    n = (count_q > NodeDepthDef) ? NodeDepthDef : int'(count_q);
    r.found = 1'b0; r.nearest_slot = '0; r.nearest_id = '0;
    r.resource_id = rid; r.distance = limit_q;
    for (int j = 0; j < n; j++) begin
      d = arc_distance(qx, qy, qz, j);
      if (d < r.distance) begin
        r.distance = d;
        r.nearest_slot = j[9:0];
        r.nearest_id = node_id[j];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      count_q = '0; radius_q = 16'd6371; limit_q = 16'hFFFF;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        RegNodeCount: count_q = cfg.data[10:0];
        RegRadius:    radius_q = cfg.data[15:0];
        RegMaxDist:   limit_q = cfg.data[15:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (in_ch.func == FuncLoad) begin
        pos_x[in_ch.slot] = in_ch.coord_x;
        pos_y[in_ch.slot] = in_ch.coord_y;
        pos_z[in_ch.slot] = in_ch.coord_z;
        node_id[in_ch.slot] = in_ch.ident;
      end else begin
        answers.push_back(nearest_node(in_ch.coord_x, in_ch.coord_y, in_ch.coord_z,
                                       in_ch.ident));
      end
    end
  end

  always @(posedge clk) begin
    answer_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (answers.size() == 0) begin
        $display("%0t: unexpected result, found %0b slot %0d dist %0d", $time,
                 out_ch.found, out_ch.nearest_slot, out_ch.distance);
        fails++;
      end else begin
        w = answers.pop_front();
        if (w.found !== out_ch.found || w.nearest_slot !== out_ch.nearest_slot ||
            w.nearest_id !== out_ch.nearest_id || w.resource_id !== out_ch.resource_id ||
            w.distance !== out_ch.distance) begin
          $display("%0t: mismatch expected found %0b slot %0d id %h rid %h dist %0d", $time,
                   w.found, w.nearest_slot, w.nearest_id, w.resource_id, w.distance);
          $display("%0t:          actual   found %0b slot %0d id %h rid %h dist %0d", $time,
                   out_ch.found, out_ch.nearest_slot, out_ch.nearest_id,
                   out_ch.resource_id, out_ch.distance);
          fails++;
        end
      end
    end
  end
endmodule

[tb/sv/nearest_node_great_circle_top_tb.sv]
// ----------------------------------------------------------------------------
// nearest_node_great_circle_top_tb
// Directed and random loads and queries under several register settings,
// with random stalls on both channels; results are checked by nngc_checker.
// ----------------------------------------------------------------------------
module nearest_node_great_circle_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nngc_pkg::*;
  import nngc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending;
  bit   idle_en = 1'b1;
  int   hold_cycles = 0;
  bit   loaded [NodeDepthDef];
  logic signed [15:0] kx [NodeDepthDef];
  logic signed [15:0] ky [NodeDepthDef];
  logic signed [15:0] kz [NodeDepthDef];

  nngc_in_if  in_ch ();
  nngc_out_if out_ch ();
  nngc_cfg_if cfg ();

  nearest_node_great_circle_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  nngc_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .fails(fails), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // result side: long hold-offs on request, otherwise random stall bursts
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic put_item(logic f, logic [9:0] s, logic [15:0] x, y, z, logic [31:0] id);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f; in_ch.slot <= s; in_ch.ident <= id;
    in_ch.coord_x <= x; in_ch.coord_y <= y; in_ch.coord_z <= z;
    if (f == FuncLoad) begin
      loaded[s] = 1'b1; kx[s] = x; ky[s] = y; kz[s] = z;
    end
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int loaded_run();
    int n;
    n = 0;
    while (n < NodeDepthDef && loaded[n]) n++;
    return n;
  endfunction

  function automatic logic [15:0] jitter(logic [15:0] v);
    return v + 16'($urandom_range(0, 600)) - 16'd300;
  endfunction

  task automatic random_item();
    int s;
    logic [15:0] x, y, z;
    if ($urandom_range(0, 9) < 3) begin
      s = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 1023))
                                       : int'($urandom_range(0, 39));
      put_item(FuncLoad, s[9:0], 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    end else begin
      s = int'($urandom_range(0, 39));
      if (loaded[s] && $urandom_range(0, 1)) begin
        x = jitter(kx[s]); y = jitter(ky[s]); z = jitter(kz[s]);
      end else begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end
      put_item(FuncQuery, 10'($urandom), x, y, z, $urandom);
    end
  endtask

  initial begin
    int n;
    in_ch.valid = 1'b0; in_ch.func = FuncLoad; in_ch.slot = '0; in_ch.ident = '0;
    in_ch.coord_x = '0; in_ch.coord_y = '0; in_ch.coord_z = '0;
    cfg.valid = 1'b0; cfg.index = RegNodeCount; cfg.data = '0;
    for (int i = 0; i < NodeDepthDef; i++) loaded[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: axis vectors, extremes, ties, clamping, empty search
    put_item(FuncLoad, 10'd0, 16'h7FFF, 16'h0000, 16'h0000, 32'h0000_0000);
    put_item(FuncLoad, 10'd1, 16'h7FFF, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    put_item(FuncLoad, 10'd2, 16'h8000, 16'h0000, 16'h0000, 32'h1234_5678);
    put_item(FuncLoad, 10'd3, 16'h0000, 16'h7FFF, 16'h0000, 32'hA5A5_5A5A);
    put_item(FuncLoad, 10'd4, 16'h0000, 16'h0000, 16'h8000, 32'h0F0F_F0F0);
    put_item(FuncLoad, 10'd5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0001);
    put_item(FuncLoad, 10'd1023, 16'h8000, 16'h8000, 16'h8000, 32'hDEAD_0001);
    put_item(FuncQuery, 10'd0, 16'h7FFF, 16'h0000, 16'h0000, 32'h0000_0001);
    drain();
    write_reg(RegNodeCount, 32'd6);
    put_item(FuncQuery, 10'd0, 16'h7FFF, 16'h0000, 16'h0000, 32'h0000_0002);
    put_item(FuncQuery, 10'd0, 16'h8000, 16'h0000, 16'h0000, 32'h0000_0003);
    put_item(FuncQuery, 10'd0, 16'h0000, 16'h0000, 16'h7FFF, 32'h0000_0004);
    put_item(FuncQuery, 10'd0, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    put_item(FuncQuery, 10'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0005);
    put_item(FuncQuery, 10'd0, 16'h8000, 16'h8000, 16'h8000, 32'h0000_0006);
    drain();
    write_reg(RegRadius, 32'd65535);
    put_item(FuncQuery, 10'd0, 16'h0000, 16'h8000, 16'h0000, 32'h0000_0007);
    put_item(FuncQuery, 10'd0, 16'h8000, 16'h0000, 16'h0000, 32'h0000_0008);
    drain();
    write_reg(RegRadius, 32'd0);
    write_reg(RegMaxDist, 32'd0);
    put_item(FuncQuery, 10'd0, 16'h7FFF, 16'h0000, 16'h0000, 32'h0000_0009);
    drain();
    write_reg(RegMaxDist, 32'd65535);
    put_item(FuncQuery, 10'd0, 16'h1234, 16'h8765, 16'h4321, 32'h0000_000A);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 40; i++)
        if (!loaded[i]) put_item(FuncLoad, i[9:0], 16'($urandom), 16'($urandom),
                                 16'($urandom), $urandom);
      drain();
      n = loaded_run();
      if (n > 40) n = 40;
      write_reg(RegNodeCount, $urandom_range(1, n));
      case (ph)
        0: write_reg(RegRadius, 32'd6371);
        1: write_reg(RegRadius, 32'd65535);
        2: write_reg(RegRadius, 32'd0);
        default: write_reg(RegRadius, $urandom);
      endcase
      case (ph)
        1: write_reg(RegMaxDist, 32'd0);
        3: write_reg(RegMaxDist, $urandom_range(0, 20000));
        default: write_reg(RegMaxDist, ($urandom_range(0, 1)) ? 32'd65535 : $urandom);
      endcase
      idle_en = (ph != 5);
      if (ph == 2) begin
        hold_cycles = 3000;
        for (int i = 0; i < 40; i++)
          put_item(FuncQuery, 10'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), $urandom);
      end
      for (int i = 0; i < 80; i++) begin
        random_item();
        if (i == 50 && ph == 1) drain();
      end
      drain();
    end

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
